/* rtl/semiconformal_projection_forward_unit_assert.svh */
// Assertion macros shared by the semiconformal projection RTL.
`ifndef SEMICONFORMAL_PROJECTION_FORWARD_UNIT_ASSERT_SVH
`define SEMICONFORMAL_PROJECTION_FORWARD_UNIT_ASSERT_SVH
// A condition that must hold at every clock edge out of reset.
`define SPF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("spf: invariant violated");
// A condition that must hold in the cycle after the trigger.
`define SPF_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("spf: sequence violated");
`endif

/* rtl/spf_pkg.sv */
// Package with the types, constants and helper functions of the projection unit.
`timescale 1ns / 1ps
package spf_pkg;
  localparam int FRAC_BITS = 28;
  localparam int DW        = 40;
  localparam int POS_W     = $clog2(DW);
  localparam int Q_SHIFT   = 32 - FRAC_BITS;
  localparam int SH_L      = (Q_SHIFT >= 0) ? Q_SHIFT : 0;
  localparam int SH_R      = (Q_SHIFT < 0) ? -Q_SHIFT : 0;

  localparam int SC_STEPS  = 32;
  localparam int LN_STEPS  = 34;
  localparam int LN_LAT    = LN_STEPS + 3;
  localparam int MUL_LAT   = 2;
  localparam int LON_DLY   = SC_STEPS + 1 + LN_LAT + 1 + MUL_LAT + SC_STEPS;

  typedef logic signed [DW-1:0] q_t;
  typedef logic signed [30:0]   out_t;

  typedef enum logic [1:0] {
    CLAMP_NONE,
    CLAMP_NEG,
    CLAMP_POS
  } clamp_t;

  localparam q_t Q_PI       = 40'sd13493037705;
  localparam q_t Q_PI_4     = 40'sd3373259426;
  localparam q_t Q_INV_2PI  = 40'sd683565276;
  localparam q_t Q_LN2      = 40'sd2977044472;
  localparam q_t Q_ALT      = 40'sd4294494850;
  localparam q_t Q_TEST     = 40'sd6684687099;
  localparam q_t Q_GAIN     = 40'sd2608131496;
  localparam q_t Q_ONE      = 40'sd4294967296;
  localparam logic signed [47:0] OUT_MAX = 48'sd1073741823;
  localparam logic signed [47:0] OUT_MIN = -48'sd1073741824;
  localparam logic signed [47:0] OUT_RND =
    (Q_SHIFT > 0) ? (48'sd1 <<< (SH_L - 1)) : 48'sd0;

  // Elementary angle atan(2^-i) or atanh(2^-i) in Q32 from its power series.
  function automatic q_t cordic_angle(input int unsigned i, input bit hyp);
    logic [63:0] s;
    logic [63:0] t;
    int unsigned k;
    s = '0;
    for (k = 0; k < 32; k++) begin
      if (i * (2 * k + 1) <= 62) begin
        t = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (!hyp && k[0]) s = s - t;
        else s = s + t;
      end
    end
    return q_t'((s + (64'd1 << 29)) >> 30);
  endfunction

  // Round a Q32 value to the output format and saturate to 31 bits.
  function automatic out_t from_q(input q_t v);
    logic signed [47:0] w;
    w = ((48'(v) + OUT_RND) >>> SH_L) <<< SH_R;
    if (w > OUT_MAX) w = OUT_MAX;
    if (w < OUT_MIN) w = OUT_MIN;
    return w[30:0];
  endfunction
endpackage

/* rtl/spf_if.sv */
// Valid/ready channel interfaces for input points and projected results.
`timescale 1ns / 1ps
interface spf_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] longitude;
  logic signed [29:0] latitude;
  modport source (output valid, output longitude, output latitude, input ready);
  modport sink (input valid, input longitude, input latitude, output ready);
endinterface

interface spf_out_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] map_x;
  logic signed [30:0] map_y;
  modport source (output valid, output map_x, output map_y, input ready);
  modport sink (input valid, input map_x, input map_y, output ready);
endinterface

/* rtl/semiconformal_projection_forward_unit.sv */
// Top level of the streaming semiconformal pseudocylindrical forward projection.
//
// Usage: points enter on in_ch (longitude signed Q3.28, latitude signed Q2.28, radians) and
// projected points leave on out_ch (map_x, map_y, signed Q3.28, saturated).
// Both channels use valid/ready; a beat moves when both are high.
// The unit is stateless: each input beat yields exactly one output beat, in order.
// Throughput is one point per cycle while the output is not stalled. An accepted
// input beat passes through one input stage, a 32-stage sine CORDIC, one clamp
// stage, a 37-stage logarithm pair, one subtract stage, a 2-stage multiplier,
// a 32-stage sine/cosine CORDIC, a 2-stage multiplier and the output register.
// All stages share one enable: when the output register holds a beat that the
// receiver does not take, the whole pipeline freezes and in_ch.ready drops in the
// same cycle, so nothing is lost or repeated. Any free output slot lets the
// pipeline advance, so a new beat is taken while an older result is still shown.
// Synchronous active-low reset clears every valid bit; data registers keep junk
// that is never presented. There are no configuration registers.
`timescale 1ns / 1ps
`include "semiconformal_projection_forward_unit_assert.svh"
module semiconformal_projection_forward_unit import spf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  spf_in_if.sink     in_ch,
  spf_out_if.source  out_ch
);
  logic   en;
  logic   s1_v_r, s2_v_r, s3_v_r, out_v_r;
  q_t     lon_q, lat_q, lon_q_r, lat_q_r;
  clamp_t cl, cl_r;
  clamp_t cl_d_r [SC_STEPS];
  logic   cl_v_r [SC_STEPS];
  q_t     lon_d_r [LON_DLY];
  q_t     p, u1_r, u2_r, d_r;
  logic   sc1_v, sc2_v, ln1_v, ln2_v, th_v, mx_v, my_v;
  q_t     sn1, cs1, sn2, cs2, ln1, ln2, theta, mx, my;
  out_t   map_x_r, map_y_r;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en          = !(out_v_r && !out_ch.ready);
  assign in_ch.ready = en;

  // Inputs are widened to the Q32 working format and the latitude clamp is decided.
  assign lon_q = (q_t'(in_ch.longitude) <<< SH_L) >>> SH_R;
  assign lat_q = (q_t'(in_ch.latitude) <<< SH_L) >>> SH_R;

  always_comb begin
    if (lat_q < -Q_TEST) cl = CLAMP_NEG;
    else if (lat_q > Q_TEST) cl = CLAMP_POS;
    else cl = CLAMP_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < SC_STEPS; k++) cl_v_r[k] <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= sc1_v;
      s3_v_r <= ln1_v;
      out_v_r <= mx_v;
      cl_v_r[0] <= s1_v_r;
      for (int k = 1; k < SC_STEPS; k++) cl_v_r[k] <= cl_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_q_r <= lon_q;
      lat_q_r <= lat_q;
      cl_r    <= cl;
      cl_d_r[0] <= cl_r;
      for (int k = 1; k < SC_STEPS; k++) cl_d_r[k] <= cl_d_r[k-1];
      lon_d_r[0] <= lon_q_r;
      for (int k = 1; k < LON_DLY; k++) lon_d_r[k] <= lon_d_r[k-1];
      u1_r <= Q_ONE + p;
      u2_r <= Q_ONE - p;
      d_r  <= ln1 - ln2;
      map_x_r <= from_q(mx);
      map_y_r <= from_q(my);
    end
  end

  spf_sincos u_sc_lat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s1_v_r), .angle(lat_q_r),
    .out_valid(sc1_v), .sin_q(sn1), .cos_q(cs1)
  );

  // The sine of the latitude is replaced by a fixed value near the poles.
  always_comb begin
    case (cl_d_r[SC_STEPS-1])
      CLAMP_NEG: p = -Q_ALT;
      CLAMP_POS: p = Q_ALT;
      default:   p = sn1;
    endcase
  end

  spf_ln u_ln_pos (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_v_r), .u(u1_r),
    .out_valid(ln1_v), .ln_q(ln1)
  );

  spf_ln u_ln_neg (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_v_r), .u(u2_r),
    .out_valid(ln2_v), .ln_q(ln2)
  );

  // theta is the log ratio scaled by one over two pi.
  spf_mulq u_mul_theta (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_v_r), .a(d_r), .b(Q_INV_2PI),
    .out_valid(th_v), .prod(theta)
  );

  spf_sincos u_sc_theta (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(th_v), .angle(theta),
    .out_valid(sc2_v), .sin_q(sn2), .cos_q(cs2)
  );

  spf_mulq u_mul_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sc2_v), .a(lon_d_r[LON_DLY-1]),
    .b(cs2), .out_valid(mx_v), .prod(mx)
  );

  spf_mulq u_mul_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sc2_v), .a(Q_PI), .b(sn2),
    .out_valid(my_v), .prod(my)
  );

  assign out_ch.valid = out_v_r;
  assign out_ch.map_x = map_x_r;
  assign out_ch.map_y = map_y_r;

  // The clamp side path must stay aligned with the first CORDIC.
  `SPF_ASSERT_ALWAYS(a_clamp_align, sc1_v == cl_v_r[SC_STEPS-1])
  // Both logarithm pipes and both output multipliers carry the same beats.
  `SPF_ASSERT_ALWAYS(a_pair_align, (ln1_v == ln2_v) && (mx_v == my_v))
  // A result the receiver refuses is held unchanged in the output register.
  `SPF_ASSERT_NEXT(a_out_hold, out_v_r && !out_ch.ready,
                   out_v_r && $stable(map_x_r) && $stable(map_y_r))
endmodule

/* rtl/spf_mulq.sv */
// Two-stage signed Q32 multiplier built from a 32x32 core and narrow partials.
`timescale 1ns / 1ps
module spf_mulq import spf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  q_t   a,
  input  q_t   b,
  output logic out_valid,
  output q_t   prod
);
  logic [DW-1:0] ma, mb;
  logic          v1_r, v2_r, neg_r;
  logic [63:0]   ll_r;
  logic [39:0]   hl_r, lh_r;
  logic [15:0]   hh_r;
  logic [47:0]   sum;
  q_t            prod_r;

  assign ma = a[DW-1] ? DW'(-a) : DW'(a);
  assign mb = b[DW-1] ? DW'(-b) : DW'(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= a[DW-1] ^ b[DW-1];
      ll_r   <= 64'(ma[31:0]) * 64'(mb[31:0]);
      hl_r   <= 40'(ma[39:32]) * 40'(mb[31:0]);
      lh_r   <= 40'(ma[31:0]) * 40'(mb[39:32]);
      hh_r   <= 16'(ma[39:32]) * 16'(mb[39:32]);
      prod_r <= neg_r ? q_t'(-sum) : q_t'(sum);
    end
  end

  // The truncated magnitude is formed before the sign, as the low partial drops its fraction.
  assign sum = {hh_r, 32'd0} + 48'(hl_r) + 48'(lh_r) + 48'(ll_r[63:32]);

  assign out_valid = v2_r;
  assign prod      = prod_r;
endmodule

/* rtl/spf_sincos.sv */
// Pipelined circular CORDIC in rotation mode, one rotation per register stage.
`timescale 1ns / 1ps
module spf_sincos import spf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  q_t   angle,
  output logic out_valid,
  output q_t   sin_q,
  output q_t   cos_q
);
  q_t   x_r [SC_STEPS];
  q_t   y_r [SC_STEPS];
  q_t   z_r [SC_STEPS];
  logic v_r [SC_STEPS];

  for (genvar j = 0; j < SC_STEPS; j++) begin : g_stg
    localparam q_t ANG = (j == 0) ? Q_PI_4 : cordic_angle(j, 1'b0);
    q_t   xp, yp, zp;
    logic vp;
    if (j == 0) begin : g_first
      assign xp = Q_GAIN;
      assign yp = '0;
      assign zp = angle;
      assign vp = in_valid;
    end else begin : g_next
      assign xp = x_r[j-1];
      assign yp = y_r[j-1];
      assign zp = z_r[j-1];
      assign vp = v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j] <= 1'b0;
      else if (en) v_r[j] <= vp;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp[DW-1]) begin
          x_r[j] <= xp - (yp >>> j);
          y_r[j] <= yp + (xp >>> j);
          z_r[j] <= zp - ANG;
        end else begin
          x_r[j] <= xp + (yp >>> j);
          y_r[j] <= yp - (xp >>> j);
          z_r[j] <= zp + ANG;
        end
      end
    end
  end

  assign out_valid = v_r[SC_STEPS-1];
  assign sin_q     = y_r[SC_STEPS-1];
  assign cos_q     = x_r[SC_STEPS-1];
endmodule

/* rtl/spf_ln.sv */
// Pipelined natural logarithm: normalize, hyperbolic CORDIC vectoring, recombine.
`timescale 1ns / 1ps
module spf_ln import spf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  q_t   u,
  output logic out_valid,
  output q_t   ln_q
);
  logic [DW-1:0]     uu, uu_r, m_b_r;
  logic [POS_W-1:0]  pos, pos_r;
  logic              va_r, vb_r, vc_r;
  logic signed [6:0] e_b_r;
  logic signed [6:0] e_r [LN_STEPS];
  q_t                x_r [LN_STEPS];
  q_t                y_r [LN_STEPS];
  q_t                z_r [LN_STEPS];
  logic              v_r [LN_STEPS];
  q_t                ln_r;

  // A non-positive argument is treated as one LSB.
  assign uu = (u[DW-1] || u == '0) ? DW'(1) : DW'(u);

  always_comb begin
    pos = '0;
    for (int b = 0; b < DW; b++) begin
      if (uu[b]) pos = POS_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= v_r[LN_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r  <= uu;
      pos_r <= pos;
      if (pos_r >= POS_W'(32)) m_b_r <= uu_r >> (pos_r - POS_W'(32));
      else m_b_r <= uu_r << (POS_W'(32) - pos_r);
      e_b_r <= $signed(7'(pos_r)) - 7'sd32;
      ln_r  <= (q_t'(e_r[LN_STEPS-1]) * Q_LN2) + (z_r[LN_STEPS-1] <<< 1);
    end
  end

  // Steps four and thirteen run twice so the hyperbolic iteration converges.
  for (genvar j = 0; j < LN_STEPS; j++) begin : g_stg
    localparam int SH = j + 1 - ((j >= 4) ? 1 : 0) - ((j >= 14) ? 1 : 0);
    localparam q_t ANG = cordic_angle(SH, 1'b1);
    q_t                xp, yp, zp;
    logic              vp;
    logic signed [6:0] ep;
    if (j == 0) begin : g_first
      assign xp = q_t'(m_b_r) + Q_ONE;
      assign yp = q_t'(m_b_r) - Q_ONE;
      assign zp = '0;
      assign vp = vb_r;
      assign ep = e_b_r;
    end else begin : g_next
      assign xp = x_r[j-1];
      assign yp = y_r[j-1];
      assign zp = z_r[j-1];
      assign vp = v_r[j-1];
      assign ep = e_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j] <= 1'b0;
      else if (en) v_r[j] <= vp;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_r[j] <= ep;
        if (!yp[DW-1]) begin
          x_r[j] <= xp - (yp >>> SH);
          y_r[j] <= yp - (xp >>> SH);
          z_r[j] <= zp + ANG;
        end else begin
          x_r[j] <= xp + (yp >>> SH);
          y_r[j] <= yp + (xp >>> SH);
          z_r[j] <= zp - ANG;
        end
      end
    end
  end

  assign out_valid = vc_r;
  assign ln_q      = ln_r;
endmodule
